// File: rtl/core/mams_pkg.sv
package mams_pkg;

  // default sizing
  localparam int unsigned DefMaxResponses = 128;
  localparam int unsigned DefValueBits    = 4;

  // fixed port widths
  localparam int unsigned ResponseW = 4;
  localparam int unsigned CountW    = 8;
  localparam int unsigned TotalW    = 11;
  localparam int unsigned MeanW     = 12;
  localparam int unsigned MedianW   = 4;
  localparam int unsigned FracBits  = 8;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_CALC,
    ST_EMIT
  } state_e;

  // command to every cell of the sort chain
  typedef struct packed {
    logic ins;    // insert din in sorted place
    logic shift;  // move one place toward cell 0
  } cell_ctrl_t;

endpackage

// File: rtl/core/mams_cell.sv
module mams_cell #(
  parameter int unsigned VW  = mams_pkg::DefValueBits,
  parameter int unsigned CW  = 8,
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  mams_pkg::cell_ctrl_t ctrl_i,
  input  logic [VW-1:0]        din_i,
  input  logic [CW-1:0]        count_i,
  input  logic [VW-1:0]        prev_val_i,
  input  logic                 prev_gt_i,
  input  logic [VW-1:0]        next_val_i,
  output logic [VW-1:0]        val_o,
  output logic                 gt_o
);

  logic [VW-1:0] val_q, val_d;

  // slot is empty or holds a larger value: the new word lands here or below
  assign gt_o = (count_i <= CW'(IDX)) || (val_q > din_i);

  // insert takes the left neighbor or the new word; drain takes the right neighbor
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = next_val_i;
    end else if (ctrl_i.ins && gt_o) begin
      val_d = prev_gt_i ? prev_val_i : din_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: rtl/core/mams_div.sv
module mams_div #(
  parameter int unsigned NW = 20,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   dvd_q, dvd_d;
  logic [NW-1:0]   quot_q, quot_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DW:0]     trial;
  logic            fits;

  // one restoring step per cycle, quotient msb first
  assign trial = {rem_q, dvd_q[NW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    dvd_d  = dvd_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[NW-2:0], 1'b0};
      quot_d = {quot_q[NW-2:0], fits};
      rem_d  = fits ? DW'(trial - {1'b0, divisor_i}) : trial[DW-1:0];
      cnt_d  = cnt_q - CntW'(1);
      busy_d = cnt_q != CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/core/mean_and_median_of_set.sv
// Collects a set of response words, one each time start is seen while busy is low, and on the word
// flagged last reports count, sum, mean (sum*256/count, 8 fraction bits,
// rounded down) and median (element count/2 of the set sorted ascending).
// Each accepted word lands in its sorted place in a chain of MAX_RESPONSES
// cells. The closing word keeps busy high while the mean comes from a
// one-bit-per-cycle divider over Q bits, Q being the sum width plus 8 (20
// at the defaults), and the median is found by draining the cell chain
// toward cell 0 count/2 places. The result sits on the outputs for the
// single cycle valid_o is high and must be captured then. Words past
// MAX_RESPONSES are dropped and raise overflow_o on the result of that set.
module mean_and_median_of_set #(
  parameter int unsigned MAX_RESPONSES = mams_pkg::DefMaxResponses,
  parameter int unsigned VALUE_BITS    = mams_pkg::DefValueBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mams_pkg::ResponseW-1:0] response_i,
  input  logic                           last_i,
  output logic                           valid_o,
  output logic [mams_pkg::CountW-1:0]    count_o,
  output logic [mams_pkg::TotalW-1:0]    total_o,
  output logic [mams_pkg::MeanW-1:0]     mean_q8_o,
  output logic [mams_pkg::MedianW-1:0]   median_o,
  output logic                           overflow_o
);

  localparam int unsigned VW = VALUE_BITS;
  localparam int unsigned CW = $clog2(MAX_RESPONSES + 1);
  localparam int unsigned SW = CW + VW;
  localparam int unsigned QW = SW + mams_pkg::FracBits;

  mams_pkg::state_e     state_q, state_d;
  mams_pkg::cell_ctrl_t ctrl;

  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] shcnt_q, shcnt_d;
  logic          accept;
  logic          full;
  logic          div_start;
  logic          div_busy;
  logic [QW-1:0] quot;
  logic [VW-1:0] din;
  logic [VW+mams_pkg::ResponseW-1:0] resp_ext;

  logic [VW-1:0] val_w [MAX_RESPONSES];
  logic          gt_w  [MAX_RESPONSES];

  // incoming word cut or widened to the value width
  assign resp_ext = {{VW{1'b0}}, response_i};
  assign din      = resp_ext[VW-1:0];

  assign accept = start && !busy;
  assign full   = count_q == CW'(MAX_RESPONSES);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mams_pkg::ST_IDLE:  if (accept && last_i) state_d = mams_pkg::ST_START;
      mams_pkg::ST_START: state_d = mams_pkg::ST_CALC;
      mams_pkg::ST_CALC:  if (!div_busy && shcnt_q == '0) state_d = mams_pkg::ST_EMIT;
      mams_pkg::ST_EMIT:  state_d = mams_pkg::ST_IDLE;
      default:            state_d = mams_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.shift = 1'b0;
    div_start  = 1'b0;
    busy       = 1'b1;
    valid_o    = 1'b0;
    unique case (state_q)
      mams_pkg::ST_IDLE: begin
        busy     = 1'b0;
        ctrl.ins = start && !full;
      end
      mams_pkg::ST_START: div_start = 1'b1;
      mams_pkg::ST_CALC:  ctrl.shift = shcnt_q != '0;
      mams_pkg::ST_EMIT:  valid_o = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  // set bookkeeping
  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    drop_d  = drop_q;
    shcnt_d = shcnt_q;
    if (accept) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
        sum_d   = sum_q + SW'(din);
      end
    end
    if (state_q == mams_pkg::ST_START) begin
      shcnt_d = count_q >> 1;
    end else if (ctrl.shift) begin
      shcnt_d = shcnt_q - CW'(1);
    end
    if (state_q == mams_pkg::ST_EMIT) begin
      count_d = '0;
      sum_d   = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mams_pkg::ST_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      drop_q  <= 1'b0;
      shcnt_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      drop_q  <= drop_d;
      shcnt_q <= shcnt_d;
    end
  end

  // sorted chain of value cells
  for (genvar i = 0; i < MAX_RESPONSES; i++) begin : g_cell
    mams_cell #(
      .VW (VW),
      .CW (CW),
      .IDX(i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .din_i     (din),
      .count_i   (count_q),
      .prev_val_i((i == 0) ? '0 : val_w[(i == 0) ? 0 : i-1]),
      .prev_gt_i ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i-1]),
      .next_val_i((i == MAX_RESPONSES-1) ? '0 : val_w[(i == MAX_RESPONSES-1) ? i : i+1]),
      .val_o     (val_w[i]),
      .gt_o      (gt_w[i])
    );
  end

  // mean divider
  mams_div #(
    .NW(QW),
    .DW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_q, {mams_pkg::FracBits{1'b0}}}),
    .divisor_i (count_q),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  // result fields cut or widened to the port widths
  logic [CW+mams_pkg::CountW-1:0]  cnt_ext;
  logic [SW+mams_pkg::TotalW-1:0]  sum_ext;
  logic [QW+mams_pkg::MeanW-1:0]   mean_ext;
  logic [VW+mams_pkg::MedianW-1:0] med_ext;

  assign cnt_ext    = {{mams_pkg::CountW{1'b0}}, count_q};
  assign sum_ext    = {{mams_pkg::TotalW{1'b0}}, sum_q};
  assign mean_ext   = {{mams_pkg::MeanW{1'b0}}, quot};
  assign med_ext    = {{mams_pkg::MedianW{1'b0}}, val_w[0]};
  assign count_o    = cnt_ext[mams_pkg::CountW-1:0];
  assign total_o    = sum_ext[mams_pkg::TotalW-1:0];
  assign mean_q8_o  = mean_ext[mams_pkg::MeanW-1:0];
  assign median_o   = med_ext[mams_pkg::MedianW-1:0];
  assign overflow_o = drop_q;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_RESPONSES))
    else $error("set count beyond capacity");

  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> count_q != '0)
    else $error("result with empty set");

  a_emit_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!div_busy && shcnt_q == '0))
    else $error("result before divider or drain finished");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (busy && div_start))
    else $error("closing word did not start the calculation");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> (count_q == '0 && sum_q == '0 && !drop_q))
    else $error("set state not cleared after result");

endmodule

// File: sim/tb_mean_and_median_of_set.sv
`timescale 1ns / 1ps

module tb_mean_and_median_of_set;

  localparam int unsigned StoreDepth = mams_pkg::DefMaxResponses;
  localparam int unsigned NumValues  = 1 << mams_pkg::DefValueBits;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned RandWords  = 740;
  localparam int unsigned TailWords  = 160;

  // one expected set summary
  typedef struct packed {
    logic [mams_pkg::CountW-1:0]  count;
    logic [mams_pkg::TotalW-1:0]  total;
    logic [mams_pkg::MeanW-1:0]   mean_q8;
    logic [mams_pkg::MedianW-1:0] median;
    logic                         overflow;
  } set_summary_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [mams_pkg::ResponseW-1:0] response_i;
  logic                           last_i;
  logic                           valid_o;
  logic [mams_pkg::CountW-1:0]    count_o;
  logic [mams_pkg::TotalW-1:0]    total_o;
  logic [mams_pkg::MeanW-1:0]     mean_q8_o;
  logic [mams_pkg::MedianW-1:0]   median_o;
  logic                           overflow_o;

  // predictor state for the open set
  int unsigned  value_hist [NumValues];
  int unsigned  set_count;
  int unsigned  set_sum;
  bit           set_dropped;
  set_summary_t pending_summaries [$];

  int unsigned errors;
  int unsigned words_taken;
  int unsigned sets_closed;
  int unsigned overflow_sets;
  int unsigned idle_cycles;
  int unsigned gap_odds;

  mean_and_median_of_set u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .response_i (response_i),
    .last_i     (last_i),
    .valid_o    (valid_o),
    .count_o    (count_o),
    .total_o    (total_o),
    .mean_q8_o  (mean_q8_o),
    .median_o   (median_o),
    .overflow_o (overflow_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // clear the open set
  task automatic clear_set();
    for (int v = 0; v < NumValues; v++) value_hist[v] = 0;
    set_count   = 0;
    set_sum     = 0;
    set_dropped = 0;
  endtask

  // fold one accepted word into the set, summarize on the closing word
  task automatic take_word(input logic [mams_pkg::ResponseW-1:0] value,
                           input logic closing);
    set_summary_t summary;
    int unsigned  rank;
    int unsigned  seen;
    bit           found;
    if (set_count < StoreDepth) begin
      value_hist[value & (NumValues - 1)]++;
      set_count++;
      set_sum += value & (NumValues - 1);
    end else begin
      set_dropped = 1;
    end
    words_taken++;
    if (closing) begin
      // median: walk the histogram up to rank count/2
      rank  = set_count / 2;
      seen  = 0;
      found = 0;
      summary.median = '0;
      for (int v = 0; v < NumValues; v++) begin
        seen += value_hist[v];
        if (!found && seen > rank) begin
          summary.median = mams_pkg::MedianW'(v);
          found = 1;
        end
      end
      summary.count    = mams_pkg::CountW'(set_count);
      summary.total    = mams_pkg::TotalW'(set_sum);
      summary.mean_q8  = mams_pkg::MeanW'((set_sum << mams_pkg::FracBits) / set_count);
      summary.overflow = set_dropped;
      pending_summaries.push_back(summary);
      sets_closed++;
      if (set_dropped) overflow_sets++;
      clear_set();
    end
  endtask

  // offer one word, hold it until the block takes it
  task automatic send_word(input logic [mams_pkg::ResponseW-1:0] value,
                           input logic closing);
    if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(18, 1)) @(negedge clk_i);
    end
    start      <= 1'b1;
    response_i <= value;
    last_i     <= closing;
    do @(posedge clk_i); while (busy);
    take_word(value, closing);
    @(negedge clk_i);
  endtask

  // one set of random length content, closed by its last word
  task automatic send_random_set(input int unsigned len);
    int unsigned flavor;
    int unsigned lo;
    int unsigned hi;
    logic [mams_pkg::ResponseW-1:0] value;
    flavor = $urandom_range(3, 0);
    lo = 0;
    hi = NumValues - 1;
    if (flavor == 1) begin
      lo = $urandom_range(NumValues - 1, 0);
      hi = lo;
    end else if (flavor == 2) begin
      lo = $urandom_range(NumValues - 4, 0);
      hi = lo + 3;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (flavor == 3) value = $urandom_range(1, 0) ? '1 : '0;
      else             value = mams_pkg::ResponseW'($urandom_range(hi, lo));
      send_word(value, i == len - 1);
    end
  endtask

  // mostly short sets, some near capacity, a few past it
  function automatic int unsigned pick_set_len();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 75)      return $urandom_range(12, 1);
    else if (sel < 93) return $urandom_range(40, 13);
    else if (sel < 98) return $urandom_range(StoreDepth, 100);
    else               return $urandom_range(StoreDepth + 8, StoreDepth + 1);
  endfunction

  // sets of one and two words, extremes and odd counts
  task automatic test_small_sets();
    gap_odds = 3;
    send_word(4'd0, 1'b1);
    send_word(4'd15, 1'b1);
    send_word(4'd0, 1'b0);
    send_word(4'd15, 1'b1);
    send_word(4'd15, 1'b0);
    send_word(4'd0, 1'b1);
    send_word(4'd5, 1'b0);
    send_word(4'd10, 1'b1);
    send_word(4'd9, 1'b0);
    send_word(4'd3, 1'b0);
    send_word(4'd12, 1'b0);
    send_word(4'd1, 1'b0);
    send_word(4'd7, 1'b1);
    for (int i = 0; i < 4; i++) send_word(4'd15, i == 3);
    for (int i = 0; i < 6; i++) send_word(4'd8, i == 5);
  endtask

  // full store with largest sums, then words dropped past capacity
  task automatic test_full_store();
    gap_odds = 6;
    for (int i = 0; i < StoreDepth; i++) send_word(4'd15, i == StoreDepth - 1);
    // closing word itself is dropped
    for (int i = 0; i < StoreDepth + 4; i++)
      send_word(mams_pkg::ResponseW'($urandom_range(15, 0)), i == StoreDepth + 3);
    // closing word is the first one past capacity
    for (int i = 0; i < StoreDepth + 1; i++)
      send_word(mams_pkg::ResponseW'($urandom_range(15, 0)), i == StoreDepth);
  endtask

  // random sets with random sender gaps
  task automatic test_random_sets();
    int unsigned start_words;
    start_words = words_taken;
    while (words_taken - start_words < RandWords) begin
      gap_odds = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 2);
      send_random_set(pick_set_len());
    end
  endtask

  // back-to-back words, no gaps
  task automatic test_back_to_back();
    int unsigned start_words;
    start_words = words_taken;
    gap_odds = 0;
    while (words_taken - start_words < TailWords)
      send_random_set($urandom_range(12, 1));
  endtask

  // field compare with report
  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    set_summary_t exp_s;
    if (rst_ni && valid_o) begin
      if (pending_summaries.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, count %0d total %0d", $time, count_o, total_o);
      end else begin
        exp_s = pending_summaries.pop_front();
        check_field("count", 32'(exp_s.count), 32'(count_o));
        check_field("total", 32'(exp_s.total), 32'(total_o));
        check_field("mean_q8", 32'(exp_s.mean_q8), 32'(mean_q8_o));
        check_field("median", 32'(exp_s.median), 32'(median_o));
        check_field("overflow", 32'(exp_s.overflow), 32'(overflow_o));
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("timeout with %0d results outstanding", pending_summaries.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    errors        = 0;
    words_taken   = 0;
    sets_closed   = 0;
    overflow_sets = 0;
    idle_cycles   = 0;
    gap_odds      = 0;
    clear_set();
    rst_ni     = 1'b0;
    start      = 1'b0;
    response_i = '0;
    last_i     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_small_sets();
    test_full_store();
    test_random_sets();
    test_back_to_back();

    start <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d words in %0d sets, %0d of them past capacity",
             words_taken, sets_closed, overflow_sets);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
